FILE: hw/rtl/isq_pkg.sv
// shared constants for the integer square root pipeline
package isq_pkg;

  // width of the root field on the result port
  localparam int unsigned ROOT_W = 16;

  // control bits that travel with each item from cell to cell
  typedef struct packed {
    logic valid;
  } isq_ctrl_t;

endpackage

FILE: hw/rtl/integer_square_root_32.sv
// integer square root, one digit cell per root bit, one item per cycle
//
//  channel   ports                         direction  transfer when
//  input     in_start, in_radicand, busy   in         in_start && !busy
//  result    out_valid, out_root           out        out_valid (one cycle)
//
// a new radicand is taken every cycle; busy is always low
// each item is registered in every cell of the chain in turn
// each cell retires two radicand bits with one compare and subtract
// reset is synchronous and clears only the valid bits along the chain
// the receiver cannot stall, so the chain never holds an item
module integer_square_root_32 #(
  parameter int unsigned INPUT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_start,
  input  logic [INPUT_WIDTH-1:0]     in_radicand,
  output logic                       busy,
  output logic                       out_valid,
  output logic [isq_pkg::ROOT_W-1:0] out_root
);
  import isq_pkg::*;

  localparam int unsigned NSTEPS = (INPUT_WIDTH - 1) / 2 + 1;
  localparam int unsigned XW     = 2 * NSTEPS;
  localparam int unsigned QW     = NSTEPS;
  localparam int unsigned RW     = QW + 2;

  isq_ctrl_t     ctrl_s [NSTEPS+1];
  logic [XW-1:0] x_s    [NSTEPS+1];
  logic [RW-1:0] rem_s  [NSTEPS+1];
  logic [QW-1:0] q_s    [NSTEPS+1];
  logic [XW-1:0] x_pad;
  logic          accept;

  // the chain never stalls, so input is always open
  assign busy   = 1'b0;
  assign accept = in_start && !busy;
  assign x_pad  = XW'(in_radicand);

  // head of the chain
  assign ctrl_s[0].valid = accept;
  assign x_s[0]          = x_pad;
  assign rem_s[0]        = '0;
  assign q_s[0]          = '0;

  // row of digit cells
  for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
    isq_cell #(
      .XW(XW),
      .QW(QW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl_s[i]),
      .x_i    (x_s[i]),
      .rem_i  (rem_s[i]),
      .q_i    (q_s[i]),
      .ctrl_o (ctrl_s[i+1]),
      .x_o    (x_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .q_o    (q_s[i+1])
    );
  end

  // result taken from the last cell's registers
  assign out_valid = ctrl_s[NSTEPS].valid;
  assign out_root  = ROOT_W'(q_s[NSTEPS]);

`ifndef ASSERT_OFF
  // a result only comes out for an accepted radicand that has passed every cell
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, NSTEPS))
    else $error("integer_square_root_32: result without a matching input");

  // root squared does not exceed the radicand
  a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((2*QW+2)'(q_s[NSTEPS]) * (2*QW+2)'(q_s[NSTEPS])
                   <= (2*QW+2)'($past(x_pad, NSTEPS))))
    else $error("integer_square_root_32: root too large");

  // next root squared is above the radicand
  a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((2*QW+2)'(q_s[NSTEPS]) + 1'b1) * ((2*QW+2)'(q_s[NSTEPS]) + 1'b1)
                   > (2*QW+2)'($past(x_pad, NSTEPS))))
    else $error("integer_square_root_32: root too small");
`endif

endmodule

FILE: hw/rtl/isq_cell.sv
// one digit cell of the square root chain: retires two radicand bits, makes one root bit
module isq_cell #(
  parameter int unsigned XW = 32,
  parameter int unsigned QW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  isq_pkg::isq_ctrl_t ctrl_i,
  input  logic [XW-1:0]      x_i,
  input  logic [QW+1:0]      rem_i,
  input  logic [QW-1:0]      q_i,
  output isq_pkg::isq_ctrl_t ctrl_o,
  output logic [XW-1:0]      x_o,
  output logic [QW+1:0]      rem_o,
  output logic [QW-1:0]      q_o
);
  import isq_pkg::*;

  localparam int unsigned RW = QW + 2;

  isq_ctrl_t     ctrl_r;
  logic [XW-1:0] x_r, x_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          ge;

  // bring down the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh  = {rem_i, x_i[XW-1:XW-2]};
    trial   = (RW+2)'({q_i, 2'b01});
    diff    = rem_sh - trial;
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? RW'(diff) : RW'(rem_sh);
    q_nxt   = QW'({q_i, ge});
    x_nxt   = x_i << 2;
  end

  // control register with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign ctrl_o = ctrl_r;
  assign x_o    = x_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;

`ifndef ASSERT_OFF
  // partial remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.valid |-> ({2'b00, rem_r} <= {3'b000, q_r, 1'b0}))
    else $error("isq_cell: remainder above twice the partial root");

  // the new root bit is set exactly when the trial fit
  a_bit_rule: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.valid |=> (q_r[0] == $past(ge)))
    else $error("isq_cell: root bit does not match trial compare");

  // an item moves one cell per cycle
  a_valid_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.valid |=> ctrl_r.valid)
    else $error("isq_cell: item lost between cells");
`endif

endmodule

FILE: bench/isq_checker.sv
// root predictor and result scoreboard for the integer square root block
module isq_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_start,
  input  logic                       busy,
  input  logic [31:0]                in_radicand,
  input  logic                       out_valid,
  input  logic [isq_pkg::ROOT_W-1:0] out_root,
  output int                         err_count,
  output int                         outstanding,
  output int                         roots_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // expected roots in transfer order
  logic [isq_pkg::ROOT_W-1:0] root_queue[$];

  // floor square root built one root bit at a time, msb first
  function automatic logic [isq_pkg::ROOT_W-1:0] floor_sqrt(input logic [31:0] value);
    logic [15:0] root;
    logic [15:0] cand;
    logic [31:0] square;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = root | (16'd1 << b);
      square = cand * cand;
      if (square <= value) begin
        root = cand;
      end
    end
    return root;
  endfunction

  // predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    logic [isq_pkg::ROOT_W-1:0] want;
    if (!rst_n) begin
      root_queue.delete();
      err_count <= 0;
      outstanding <= 0;
      roots_checked <= 0;
    end else begin
      if (in_start && !busy) begin
        root_queue.push_back(floor_sqrt(in_radicand));
      end
      if (out_valid) begin
        if (root_queue.size() == 0) begin
          if (err_count < REPORT_LIMIT) begin
            $display("%0t: unexpected result root=%0d", $realtime, out_root);
          end
          err_count <= err_count + 1;
        end else begin
          want = root_queue.pop_front();
          roots_checked <= roots_checked + 1;
          if (out_root !== want) begin
            if (err_count < REPORT_LIMIT) begin
              $display("%0t: root mismatch expected=%0d actual=%0d",
                       $realtime, want, out_root);
            end
            err_count <= err_count + 1;
          end
        end
      end
      outstanding <= root_queue.size();
    end
  end

endmodule

FILE: bench/tb.sv
// top of the integer square root bench: clock, reset, radicand stimulus, verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    PICK_UNIFORM,
    PICK_SQUARE,
    PICK_BELOW_SQUARE,
    PICK_TOP_OF_SPAN,
    PICK_SMALL,
    PICK_HIGH
  } pick_e;

  localparam int ITEMS_PER_PHASE = 550;
  localparam int DRAIN_CYCLES = 40;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_start = 1'b0;
  logic [31:0]                in_radicand = '0;
  logic                       busy;
  logic                       out_valid;
  logic [isq_pkg::ROOT_W-1:0] out_root;

  int err_count;
  int outstanding;
  int roots_checked;
  int radicands_sent = 0;
  int idle_pct;

  integer_square_root_32 dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_start    (in_start),
    .in_radicand (in_radicand),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_root    (out_root)
  );

  isq_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_start      (in_start),
    .busy          (busy),
    .in_radicand   (in_radicand),
    .out_valid     (out_valid),
    .out_root      (out_root),
    .err_count     (err_count),
    .outstanding   (outstanding),
    .roots_checked (roots_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the result stream hangs
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  // one input transfer, preceded by random idle cycles
  task automatic send_radicand(input logic [31:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_start <= 1'b0;
      @(posedge clk);
    end
    in_start <= 1'b1;
    in_radicand <= value;
    do @(posedge clk); while (busy);
    radicands_sent++;
  endtask

  // radicand mix that favors squares and their neighbors
  function automatic logic [31:0] pick_radicand();
    logic [31:0] r;
    pick_e kind;
    r = $urandom_range(65535);
    kind = pick_e'($urandom_range(PICK_HIGH));
    unique case (kind)
      PICK_SQUARE:       return r * r;
      PICK_BELOW_SQUARE: return r * r - 32'd1;
      PICK_TOP_OF_SPAN:  return r * r + 2 * r;
      PICK_SMALL:        return $urandom_range(1023);
      PICK_HIGH:         return 32'hFFFF_0000 | $urandom_range(65535);
      default:           return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] directed[$];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15, 32'd16,
                 32'd99, 32'd100, 32'hFFFF_FFFF, 32'hFFFE_0001, 32'hFFFE_0000,
                 32'h8000_0000, 32'h4000_0000, 32'h3FFF_FFFF, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h0001_0000, 32'h0000_FFFF, 32'hFFFE_FFFF,
                 32'h7FFF_FFFF, 32'h0100_0000, 32'h00FF_FFFF};
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, back to back
    foreach (directed[i]) send_radicand(directed[i]);

    // random phases: light sender gaps, heavy sender gaps, then none
    idle_pct = 14;
    repeat (ITEMS_PER_PHASE) send_radicand(pick_radicand());
    idle_pct = 77;
    repeat (ITEMS_PER_PHASE) send_radicand(pick_radicand());
    idle_pct = 0;
    repeat (ITEMS_PER_PHASE) send_radicand(pick_radicand());
    in_start <= 1'b0;

    // drain the pipeline
    @(posedge clk);
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d radicands (corners, squares and neighbors, random words)",
             radicands_sent);
    $display("checked %0d roots under three sender pacing phases", roots_checked);
    if (outstanding != 0) begin
      $display("%0d roots never arrived", outstanding);
    end
    if (err_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
